@@ sv/buddy_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator package
// Shared request/result types and status codes.
// ----------------------------------------------------------------------------
package buddy_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_MEM   = 2'd2;
    localparam logic [1:0] ST_BAD_PTR  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] request_size;
        logic [15:0] payload_address;
    } buddy_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_address;
        logic [3:0]  granted_order;
        logic        padded;
    } buddy_rsp_t;

endpackage

@@ sv/buddy_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Buddy allocator core
// Binary buddy allocator with free lists and block headers in on-chip memory.
// ----------------------------------------------------------------------------
// channel   ports                     transfer
// request   start, busy, req          start && !busy
// result    done, rsp                 done (one cycle, no stall)
//
// A rejected request goes to DONE from IDLE, ASCAN, FRD or FCHK. An allocate
// runs ASCAN, POP and RM1 (or GROW when the heap grows), SPLIT, PUSH and
// PUSH2 per split level, AFIN and DONE; a free runs FRD, FCHK, MRD, MCHK
// and MRM per merge level, then PUSH, PUSH2 and DONE. done rises in the
// first cycle busy is low again. After reset a clearing pass zeroes headers
// and free marks, one slot a cycle, with busy held high.
// The receiver cannot stall; busy stays high from accept to done.
module buddy_allocator_core
    import buddy_pkg::*;
#(
    parameter int MIN_ORDER    = 5,
    parameter int ORDER_LIMIT  = 15,
    parameter int HEAP_REGIONS = 4
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  buddy_req_t req,
    output logic       done,
    output buddy_rsp_t rsp
);

    localparam int HDR      = 8;
    localparam int TOP      = ORDER_LIMIT - 1;
    localparam int NLISTS   = ORDER_LIMIT - MIN_ORDER;
    localparam int SPR      = 1 << (TOP - MIN_ORDER);
    localparam int NSLOTS   = HEAP_REGIONS * SPR;
    localparam int SW       = $clog2(NSLOTS + 1);
    localparam int LW       = $clog2(NLISTS);
    localparam int RW       = $clog2(HEAP_REGIONS + 1);
    localparam int OW       = 5;
    localparam int SZW      = 17;
    localparam int HW       = 2 + OW + SZW;
    localparam int IW       = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam logic [SW-1:0] NIL = SW'(NSLOTS);

    localparam logic [5:0] S_CLR    = 6'd0;
    localparam logic [5:0] S_IDLE   = 6'd1;
    localparam logic [5:0] S_ASCAN  = 6'd2;
    localparam logic [5:0] S_GROW   = 6'd3;
    localparam logic [5:0] S_POP    = 6'd4;   // issue reads of s links
    localparam logic [5:0] S_RM1    = 6'd5;   // links valid
    localparam logic [5:0] S_RM2    = 6'd6;   // patch n.prev
    localparam logic [5:0] S_SPLIT  = 6'd7;
    localparam logic [5:0] S_PUSH   = 6'd8;   // push pslot at porder
    localparam logic [5:0] S_PUSH2  = 6'd9;
    localparam logic [5:0] S_AFIN   = 6'd10;
    localparam logic [5:0] S_FRD    = 6'd11;
    localparam logic [5:0] S_FCHK   = 6'd12;
    localparam logic [5:0] S_MRD    = 6'd13;
    localparam logic [5:0] S_MCHK   = 6'd14;
    localparam logic [5:0] S_DONE   = 6'd15;
    localparam logic [5:0] S_MRM    = 6'd16;

    logic [HW-1:0] hdr_mem [NSLOTS];
    logic          fl_mem  [NSLOTS];
    logic [SW-1:0] nx_mem  [NSLOTS];
    logic [SW-1:0] pv_mem  [NSLOTS];

    logic [HW-1:0] hdr_q;
    logic          fl_q;
    logic [SW-1:0] nx_q, pv_q;

    logic          hdr_we, fl_we, nx_we, pv_we;
    logic [IW-1:0] hdr_wa, fl_wa, nx_wa, pv_wa, h_ra, l_ra;
    logic [HW-1:0] hdr_wd;
    logic          fl_wd;
    logic [SW-1:0] nx_wd, pv_wd;

    always_ff @(posedge clk)
    begin
        if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
        if (fl_we)  fl_mem[fl_wa]   <= fl_wd;
        if (nx_we)  nx_mem[nx_wa]   <= nx_wd;
        if (pv_we)  pv_mem[pv_wa]   <= pv_wd;
        hdr_q <= hdr_mem[h_ra];
        fl_q  <= fl_mem[h_ra];
        nx_q  <= nx_mem[l_ra];
        pv_q  <= pv_mem[l_ra];
    end

    logic [SW-1:0] head_reg [NLISTS];
    logic [SW-1:0] head_next [NLISTS];
    logic [5:0]    state_reg, state_next;
    logic [RW-1:0] regions_reg, regions_next;
    logic [15:0]   size_reg, size_next;
    logic [15:0]   ptr_reg, ptr_next;
    logic [OW-1:0] want_reg, want_next;
    logic [OW-1:0] ord_reg, ord_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [SW-1:0] rs_reg, rs_next;       // slot being removed
    logic [OW-1:0] ro_reg, ro_next;
    logic [5:0]    ret_reg, ret_next;     // state after remove/push
    logic [SW-1:0] ps_reg, ps_next;
    logic [OW-1:0] po_reg, po_next;
    logic [SW-1:0] ln_reg, ln_next;       // old list head during a push
    logic          done_reg, done_next;
    buddy_rsp_t    rsp_reg, rsp_next;

    function automatic logic [OW-1:0] order_for(input logic [15:0] sz);
        logic [OW-1:0] o;
        o = OW'(MIN_ORDER);
        for (int k = MIN_ORDER; k < TOP; k++)
            if ((17'd1 << k) < ({1'b0, sz} + 17'(HDR)))
                o = OW'(k + 1);
        return o;
    endfunction

    function automatic logic [IW-1:0] ix(input logic [SW-1:0] s);
        return s[IW-1:0];
    endfunction

    function automatic logic [LW-1:0] li(input logic [OW-1:0] o);
        return LW'(o - OW'(MIN_ORDER));
    endfunction

    function automatic logic [HW-1:0] mkh(input logic a, input logic p,
                                          input logic [OW-1:0] o,
                                          input logic [15:0] sz);
        return {1'b0, sz, o, p, a};
    endfunction

    // alloc scan: first non-empty list at or above want
    logic          scan_hit;
    logic [OW-1:0] scan_ord;
    always_comb
    begin
        scan_hit = 1'b0;
        scan_ord = want_reg;
        for (int k = NLISTS - 1; k >= 0; k--)
            if (OW'(k + MIN_ORDER) >= want_reg && head_reg[k] != NIL)
            begin
                scan_hit = 1'b1;
                scan_ord = OW'(k + MIN_ORDER);
            end
    end

    logic [16:0] blk_lim;
    logic [OW-1:0] h_ord;
    logic [15:0] h_sz;
    logic [16:0] h_lim;
    logic [SW-1:0] bud;
    logic [16:0] heap_top;
    logic [15:0] addr;
    assign blk_lim  = 17'((32'd1 << TOP) - HDR);
    assign h_ord    = hdr_q[6:2];
    assign h_sz     = hdr_q[22:7];
    assign h_lim    = (h_ord <= OW'(16)) ? 17'((32'd1 << h_ord) - HDR) : 17'h1FFFF;
    assign heap_top = 17'(32'(regions_reg) << TOP);
    assign addr     = ptr_reg - 16'(HDR);
    assign bud      = slot_reg ^ SW'(32'd1 << (ord_reg - OW'(MIN_ORDER)));

    always_comb
    begin
        state_next   = state_reg;
        regions_next = regions_reg;
        size_next = size_reg; ptr_next = ptr_reg;
        want_next = want_reg; ord_next = ord_reg; slot_next = slot_reg;
        rs_next = rs_reg; ro_next = ro_reg; ret_next = ret_reg;
        ps_next = ps_reg; po_next = po_reg; ln_next = ln_reg;
        head_next = head_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        hdr_we = 1'b0; fl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
        hdr_wa = ix(slot_reg); fl_wa = ix(slot_reg);
        nx_wa = ix(slot_reg); pv_wa = ix(slot_reg);
        hdr_wd = '0; fl_wd = 1'b0; nx_wd = NIL; pv_wd = NIL;
        h_ra = ix(slot_reg); l_ra = ix(rs_reg);
        unique case (state_reg)
            S_CLR:
            begin
                hdr_we = 1'b1; fl_we = 1'b1;
                if (slot_reg == SW'(NSLOTS - 1))
                    state_next = S_IDLE;
                else
                    slot_next = slot_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    size_next = req.request_size;
                    ptr_next = req.payload_address;
                    want_next = order_for(req.request_size);
                    if (req.op == OP_FREE)
                        state_next = S_FRD;
                    else if (req.request_size == 16'd0 ||
                             {1'b0, req.request_size} > blk_lim)
                    begin
                        rsp_next = '{ST_BAD_SIZE, 16'd0, 4'd0, 1'b0};
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_ASCAN;
                end
            end
            S_ASCAN:
            begin
                if (scan_hit)
                begin
                    ord_next = scan_ord;
                    slot_next = head_reg[li(scan_ord)];
                    rs_next = head_reg[li(scan_ord)];
                    ro_next = scan_ord;
                    ret_next = S_SPLIT;
                    state_next = S_POP;
                end
                else if (32'(regions_reg) >= HEAP_REGIONS)
                begin
                    rsp_next = '{ST_NO_MEM, 16'd0, 4'd0, 1'b0};
                    state_next = S_DONE;
                end
                else
                    state_next = S_GROW;
            end
            S_GROW:
            begin
                // fresh region: its top block is taken at once, list untouched
                slot_next = SW'(32'(regions_reg) * SPR);
                regions_next = regions_reg + 1'b1;
                ord_next = OW'(TOP);
                hdr_we = 1'b1; hdr_wa = ix(SW'(32'(regions_reg) * SPR));
                hdr_wd = mkh(1'b0, 1'b0, OW'(TOP), 16'd0);
                state_next = S_SPLIT;
            end
            S_POP:
            begin
                l_ra = ix(rs_reg);
                state_next = S_RM1;
            end
            S_RM1:
            begin
                fl_we = 1'b1; fl_wa = ix(rs_reg); fl_wd = 1'b0;
                if (pv_q != NIL)
                begin
                    nx_we = 1'b1; nx_wa = ix(pv_q); nx_wd = nx_q;
                end
                else
                    head_next[li(ro_reg)] = nx_q;
                if (nx_q != NIL)
                begin
                    pv_we = 1'b1; pv_wa = ix(nx_q); pv_wd = pv_q;
                end
                state_next = ret_reg;
            end
            S_SPLIT:
            begin
                if (ord_reg > want_reg)
                begin
                    ord_next = ord_reg - 1'b1;
                    ps_next = slot_reg + SW'(32'd1 << (ord_reg - 1'b1 - OW'(MIN_ORDER)));
                    po_next = ord_reg - 1'b1;
                    hdr_we = 1'b1;
                    hdr_wa = ix(slot_reg + SW'(32'd1 << (ord_reg - 1'b1 - OW'(MIN_ORDER))));
                    hdr_wd = mkh(1'b0, 1'b0, ord_reg - 1'b1, 16'd0);
                    ret_next = S_SPLIT;
                    state_next = S_PUSH;
                end
                else
                    state_next = S_AFIN;
            end
            S_PUSH:
            begin
                nx_we = 1'b1; nx_wa = ix(ps_reg); nx_wd = head_reg[li(po_reg)];
                pv_we = 1'b1; pv_wa = ix(ps_reg); pv_wd = NIL;
                fl_we = 1'b1; fl_wa = ix(ps_reg); fl_wd = 1'b1;
                ln_next = head_reg[li(po_reg)];
                head_next[li(po_reg)] = ps_reg;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                // old head points back at the new one
                if (ln_reg != NIL)
                begin
                    pv_we = 1'b1; pv_wa = ix(ln_reg); pv_wd = ps_reg;
                end
                state_next = ret_reg;
            end
            S_AFIN:
            begin
                hdr_we = 1'b1;
                hdr_wd = mkh(1'b1, ({1'b0, size_reg} != 17'((32'd1 << want_reg) - HDR)),
                             want_reg, size_reg);
                rsp_next.status = ST_OK;
                rsp_next.granted_address = 16'((32'(slot_reg) << MIN_ORDER) + HDR);
                rsp_next.granted_order = 4'(want_reg);
                rsp_next.padded = ({1'b0, size_reg} != 17'((32'd1 << want_reg) - HDR));
                state_next = S_DONE;
            end
            S_FRD:
            begin
                slot_next = SW'(addr >> MIN_ORDER);
                h_ra = ix(SW'(addr >> MIN_ORDER));
                if (ptr_reg < 16'(HDR) || {1'b0, ptr_reg} >= heap_top ||
                    addr[MIN_ORDER-1:0] != '0)
                begin
                    rsp_next = '{ST_BAD_PTR, 16'd0, 4'd0, 1'b0};
                    state_next = S_DONE;
                end
                else
                    state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (h_ord < OW'(MIN_ORDER) || h_ord > OW'(TOP) || !hdr_q[0] ||
                    {1'b0, h_sz} > h_lim ||
                    hdr_q[1] != ({1'b0, h_sz} != h_lim) || order_for(h_sz) != h_ord)
                begin
                    rsp_next = '{ST_BAD_PTR, 16'd0, 4'd0, 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    hdr_we = 1'b1; hdr_wd = {hdr_q[HW-1:1], 1'b0};
                    ord_next = h_ord;
                    state_next = S_MRD;
                end
            end
            S_MRD:
            begin
                if (ord_reg >= OW'(TOP) || bud >= NIL)
                begin
                    ps_next = slot_reg; po_next = ord_reg;
                    ret_next = S_DONE;
                    rsp_next = '{ST_OK, 16'd0, 4'd0, 1'b0};
                    state_next = S_PUSH;
                end
                else
                begin
                    h_ra = ix(bud); l_ra = ix(bud);
                    rs_next = bud; ro_next = ord_reg;
                    state_next = S_MCHK;
                end
            end
            S_MCHK:
            begin
                if (h_ord != ord_reg || hdr_q[0] || !fl_q)
                begin
                    ps_next = slot_reg; po_next = ord_reg;
                    ret_next = S_DONE;
                    rsp_next = '{ST_OK, 16'd0, 4'd0, 1'b0};
                    state_next = S_PUSH;
                end
                else
                begin
                    // links of buddy are on the read port now: unlink
                    fl_we = 1'b1; fl_wa = ix(rs_reg); fl_wd = 1'b0;
                    if (pv_q != NIL)
                    begin
                        nx_we = 1'b1; nx_wa = ix(pv_q); nx_wd = nx_q;
                    end
                    else
                        head_next[li(ord_reg)] = nx_q;
                    if (nx_q != NIL)
                    begin
                        pv_we = 1'b1; pv_wa = ix(nx_q); pv_wd = pv_q;
                    end
                    state_next = S_MRM;
                end
            end
            S_MRM:
            begin
                slot_next = (rs_reg < slot_reg) ? rs_reg : slot_reg;
                ord_next = ord_reg + 1'b1;
                hdr_we = 1'b1;
                hdr_wa = ix((rs_reg < slot_reg) ? rs_reg : slot_reg);
                hdr_wd = mkh(1'b0, 1'b0, ord_reg + 1'b1, 16'd0);
                state_next = S_MRD;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            regions_reg <= '0;
            slot_reg <= '0;
            done_reg <= 1'b0;
            for (int k = 0; k < NLISTS; k++)
                head_reg[k] <= NIL;
        end
        else
        begin
            state_reg <= state_next;
            regions_reg <= regions_next;
            slot_reg <= slot_next;
            done_reg <= done_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next; ptr_reg <= ptr_next;
        want_reg <= want_next; ord_reg <= ord_next;
        rs_reg <= rs_next; ro_reg <= ro_next; ret_reg <= ret_next;
        ps_reg <= ps_next; po_reg <= po_next; ln_reg <= ln_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("done outside idle");
    a_regions: assert property (@(posedge clk) disable iff (!rst_n)
        32'(regions_reg) <= HEAP_REGIONS) else $error("region overflow");

endmodule

@@ tb/buddy_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy allocator core testbench
// Drives directed allocate/free commands, then random bursts, predicts each result with a
// behavioral buddy model and compares every field of every result strobe.
// ----------------------------------------------------------------------------
module buddy_allocator_core_tb
    import buddy_pkg::*;
();

    localparam int MIN_ORD    = 5;
    localparam int ORD_LIM    = 15;
    localparam int REGIONS    = 4;
    localparam int HDR        = 8;
    localparam int TOP        = ORD_LIM - 1;
    localparam int NLISTS     = ORD_LIM - MIN_ORD;
    localparam int SLOTS_REG  = 1 << (TOP - MIN_ORD);
    localparam int NSLOTS     = REGIONS * SLOTS_REG;
    localparam int NIL        = NSLOTS;
    localparam int RANDOM_ITEMS = 1100;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic       used;
        logic       pad;
        int         ord;
        int         size;
    } hdr_t;

    typedef struct {
        buddy_req_t req;
        logic       chk;
        buddy_rsp_t rsp;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    buddy_req_t req;
    logic       done;
    buddy_rsp_t rsp;

    buddy_allocator_core #(
        .MIN_ORDER   (MIN_ORD),
        .ORDER_LIMIT (ORD_LIM),
        .HEAP_REGIONS(REGIONS)
    ) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    // allocator mirror
    hdr_t heap_hdr[NSLOTS];
    bit   free_mark[NSLOTS];
    int   link_next[NSLOTS];
    int   link_prev[NSLOTS];
    int   head[NLISTS];
    int   grown;

    buddy_rsp_t pending_rsp[$];
    logic       pending_typed[$];
    buddy_rsp_t pending_typed_rsp[$];
    int         live_ptrs[$];
    int         mismatches;
    longint     cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int order_needed(int sz);
        int o;
        o = MIN_ORD;
        while (o < TOP && (1 << o) < sz + HDR)
            o++;
        return o;
    endfunction

    function automatic void push_free(int s, int o);
        int h;
        h = head[o - MIN_ORD];
        link_next[s] = h;
        link_prev[s] = NIL;
        if (h < NSLOTS)
            link_prev[h] = s;
        head[o - MIN_ORD] = s;
        free_mark[s] = 1;
    endfunction

    function automatic void unlink_free(int s, int o);
        int p;
        int n;
        p = link_prev[s];
        n = link_next[s];
        if (p < NSLOTS)
            link_next[p] = n;
        else
            head[o - MIN_ORD] = n;
        if (n < NSLOTS)
            link_prev[n] = p;
        free_mark[s] = 0;
    endfunction

    function automatic hdr_t mk_hdr(logic u, logic p, int o, int sz);
        hdr_t h;
        h.used = u;
        h.pad = p;
        h.ord = o;
        h.size = sz;
        return h;
    endfunction

    function automatic buddy_rsp_t predict_alloc(int sz);
        buddy_rsp_t r;
        int want;
        int o;
        int s;
        int hi;
        logic pad;
        r = '0;
        if (sz == 0 || sz > (1 << TOP) - HDR)
        begin
            r.status = ST_BAD_SIZE;
            return r;
        end
        want = order_needed(sz);
        o = want;
        while (o <= TOP && head[o - MIN_ORD] >= NSLOTS)
            o++;
        if (o > TOP)
        begin
            if (grown >= REGIONS)
            begin
                r.status = ST_NO_MEM;
                return r;
            end
            s = grown * SLOTS_REG;
            heap_hdr[s] = mk_hdr(0, 0, TOP, 0);
            push_free(s, TOP);
            grown++;
            o = TOP;
        end
        s = head[o - MIN_ORD];
        unlink_free(s, o);
        while (o > want)
        begin
            o--;
            hi = s + (1 << (o - MIN_ORD));
            heap_hdr[hi] = mk_hdr(0, 0, o, 0);
            push_free(hi, o);
        end
        pad = ((1 << want) - HDR) != sz;
        heap_hdr[s] = mk_hdr(1, pad, want, sz);
        r.status = ST_OK;
        r.granted_address = 16'((s << MIN_ORD) + HDR);
        r.granted_order = 4'(want);
        r.padded = pad;
        return r;
    endfunction

    function automatic buddy_rsp_t predict_free(int ptr);
        buddy_rsp_t r;
        int addr;
        int s;
        int o;
        int b;
        hdr_t h;
        hdr_t bh;
        r = '0;
        r.status = ST_BAD_PTR;
        if (ptr < HDR || ptr >= (grown << TOP))
            return r;
        addr = ptr - HDR;
        if ((addr & ((1 << MIN_ORD) - 1)) != 0)
            return r;
        s = addr >> MIN_ORD;
        if (s >= NSLOTS)
            return r;
        h = heap_hdr[s];
        o = h.ord;
        if (o < MIN_ORD || o > TOP || !h.used || h.size > (1 << o) - HDR)
            return r;
        if (h.pad != (((1 << o) - HDR) != h.size) || order_needed(h.size) != o)
            return r;
        heap_hdr[s].used = 0;
        while (o < TOP)
        begin
            b = s ^ (1 << (o - MIN_ORD));
            if (b >= NSLOTS)
                break;
            bh = heap_hdr[b];
            if (bh.ord != o || bh.used || !free_mark[b])
                break;
            unlink_free(b, o);
            if (b < s)
                s = b;
            o++;
            heap_hdr[s] = mk_hdr(0, 0, o, 0);
        end
        push_free(s, o);
        r.status = ST_OK;
        return r;
    endfunction

    // skewed size: mostly small, some large, a few extremes
    function automatic int pick_size();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return $urandom_range(1, 200);
        else if (k < 90)
            return $urandom_range(1, 2000);
        else if (k < 97)
            return $urandom_range(1, (1 << TOP) - HDR);
        return $urandom_range(0, 65535);
    endfunction

    // one transfer, prediction taken at acceptance
    task automatic send(buddy_req_t r, logic typed, buddy_rsp_t exp_r);
        buddy_rsp_t p;
        req <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.op == OP_ALLOC)
            p = predict_alloc(int'(r.request_size));
        else
            p = predict_free(int'(r.payload_address));
        if (r.op == OP_ALLOC && p.status == ST_OK)
            live_ptrs.push_back(int'(p.granted_address));
        pending_rsp.push_back(p);
        pending_typed.push_back(typed);
        pending_typed_rsp.push_back(exp_r);
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    endtask

    function automatic buddy_req_t mk_req(logic op, int sz, int ptr);
        buddy_req_t r;
        r.op = op;
        r.request_size = 16'(sz);
        r.payload_address = 16'(ptr);
        return r;
    endfunction

    function automatic buddy_rsp_t mk_rsp(logic [1:0] st, int a, int o, logic p);
        buddy_rsp_t r;
        r.status = st;
        r.granted_address = 16'(a);
        r.granted_order = 4'(o);
        r.padded = p;
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        buddy_rsp_t e;
        buddy_rsp_t t;
        logic ty;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", rsp);
            end
            else
            begin
                e = pending_rsp.pop_front();
                ty = pending_typed.pop_front();
                t = pending_typed_rsp.pop_front();
                if (ty && t !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row disagrees: table %p model %p", t, e);
                end
                if (rsp.status !== e.status || rsp.granted_address !== e.granted_address
                    || rsp.granted_order !== e.granted_order || rsp.padded !== e.padded)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, rsp);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("buddy_allocator_core_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        int k;
        int sz;
        int ptr;
        int burst;
        mismatches = 0;
        cycles = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            heap_hdr[i] = mk_hdr(0, 0, 0, 0);
            free_mark[i] = 0;
            link_next[i] = 0;
            link_prev[i] = 0;
        end
        for (int i = 0; i < NLISTS; i++)
            head[i] = NIL;
        grown = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty heap errors, extremes, splits, merges, bad pointers
        rows.push_back('{mk_req(OP_FREE, 0, 8), 1, mk_rsp(ST_BAD_PTR, 0, 0, 0)});
        rows.push_back('{mk_req(OP_ALLOC, 0, 0), 1, mk_rsp(ST_BAD_SIZE, 0, 0, 0)});
        rows.push_back('{mk_req(OP_ALLOC, 65535, 65535), 1,
                         mk_rsp(ST_BAD_SIZE, 0, 0, 0)});
        rows.push_back('{mk_req(OP_ALLOC, (1 << TOP) - HDR + 1, 0), 1,
                         mk_rsp(ST_BAD_SIZE, 0, 0, 0)});
        rows.push_back('{mk_req(OP_ALLOC, 24, 0), 1, mk_rsp(ST_OK, 8, MIN_ORD, 0)});
        rows.push_back('{mk_req(OP_ALLOC, 1, 0), 1, mk_rsp(ST_OK, 40, MIN_ORD, 1)});
        rows.push_back('{mk_req(OP_ALLOC, 25, 0), 0, '0});
        rows.push_back('{mk_req(OP_FREE, 0, 40), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, 40), 1, mk_rsp(ST_BAD_PTR, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, 41), 1, mk_rsp(ST_BAD_PTR, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, 7), 1, mk_rsp(ST_BAD_PTR, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, 65535), 1, mk_rsp(ST_BAD_PTR, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, 8 + 64), 0, '0});
        rows.push_back('{mk_req(OP_FREE, 0, 8), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(OP_ALLOC, (1 << TOP) - HDR, 0), 1,
                         mk_rsp(ST_OK, 8, TOP, 0)});
        rows.push_back('{mk_req(OP_ALLOC, (1 << TOP) - HDR, 0), 1,
                         mk_rsp(ST_OK, (1 << TOP) + 8, TOP, 0)});
        rows.push_back('{mk_req(OP_ALLOC, 16000, 0), 0, '0});
        rows.push_back('{mk_req(OP_ALLOC, 16383, 0), 0, '0});
        rows.push_back('{mk_req(OP_ALLOC, 9000, 0), 0, '0});
        rows.push_back('{mk_req(OP_ALLOC, 1, 0), 1, mk_rsp(ST_NO_MEM, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, 8), 1, mk_rsp(ST_OK, 0, 0, 0)});
        rows.push_back('{mk_req(OP_FREE, 0, (1 << TOP) + 8), 0, '0});
        rows.push_back('{mk_req(OP_FREE, 0, 16'hAAAA), 0, '0});
        rows.push_back('{mk_req(OP_FREE, 0, 16'h5555), 0, '0});
        foreach (rows[i])
            send(rows[i].req, rows[i].chk, rows[i].rsp);
        live_ptrs.delete();

        // free all outstanding blocks so the random part starts from a clean heap
        for (int a = 0; a < (REGIONS << TOP); a += (1 << MIN_ORD))
            if (heap_hdr[a >> MIN_ORD].used)
                send(mk_req(OP_FREE, $urandom, a + HDR), 0, '0);

        k = 0;
        while (k < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && k < RANDOM_ITEMS; j++, k++)
            begin
                sz = $urandom_range(0, 99);
                if (sz < 50 || live_ptrs.size() == 0)
                    send(mk_req(OP_ALLOC, pick_size(), $urandom), 0, '0);
                else if (sz < 90)
                begin
                    ptr = $urandom_range(0, live_ptrs.size() - 1);
                    send(mk_req(OP_FREE, $urandom, live_ptrs[ptr]), 0, '0);
                    live_ptrs.delete(ptr);
                end
                else if (sz < 95)
                    send(mk_req(OP_FREE, $urandom,
                                live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]
                                + $urandom_range(0, 2) * 32), 0, '0);
                else
                    send(mk_req(OP_FREE, $urandom, $urandom), 0, '0);
            end
            start <= 1'b0;
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 60)) @(negedge clk);
            else
                @(negedge clk);
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("buddy_allocator_core_tb: PASS");
        else
            $display("buddy_allocator_core_tb: FAIL");
        $finish;
    end

endmodule
